FILE: src/p2f_pkg.sv
// ----------------------------------------------------------------------------
// p2f_pkg: shared types and constants for the PCM to float32 converter
// Sample format codes, float constants and the stage-to-stage struct.
// ----------------------------------------------------------------------------
`default_nettype none
package p2f_pkg;
    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S32 = 2'd1;
    localparam logic [1:0] FMT_U8  = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    localparam logic [31:0] F32_POS_ONE = 32'h3F80_0000;
    localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;
    localparam logic [31:0] F32_INF     = 32'h7F80_0000;

    // sign/magnitude form handed from the front end to the packer
    typedef struct packed {
        logic        is_float;
        logic        neg;
        logic [31:0] mag;      // integer magnitude, or raw float word
        logic [7:0]  exp_bias; // 127 - scale
        logic        last;
    } t_p2f_pre;
endpackage
`default_nettype wire

FILE: src/p2f_front.sv
// ----------------------------------------------------------------------------
// p2f_front: sample decode
// Splits the raw sample into sign and magnitude according to the format.
// ----------------------------------------------------------------------------
`default_nettype none
module p2f_front (
    input  wire logic [1:0]       i_fmt,
    input  wire logic [31:0]      i_raw,
    input  wire logic             i_last,
    output p2f_pkg::t_p2f_pre     o_pre
);
    always_comb begin
        o_pre          = '0;
        o_pre.last     = i_last;
        case (i_fmt)
            p2f_pkg::FMT_S16: begin
                o_pre.neg      = i_raw[15];
                o_pre.mag      = i_raw[15] ? (32'h0001_0000 - {16'd0, i_raw[15:0]})
                                           : {16'd0, i_raw[15:0]};
                o_pre.exp_bias = 8'd112;
            end
            p2f_pkg::FMT_S32: begin
                o_pre.neg      = i_raw[31];
                o_pre.mag      = i_raw[31] ? (32'd0 - i_raw) : i_raw;
                o_pre.exp_bias = 8'd96;
            end
            p2f_pkg::FMT_U8: begin
                o_pre.neg      = ~i_raw[7];
                o_pre.mag      = i_raw[7] ? {24'd0, 1'b0, i_raw[6:0]}
                                          : (32'd128 - {24'd0, i_raw[7:0]});
                o_pre.exp_bias = 8'd120;
            end
            default: begin
                o_pre.is_float = 1'b1;
                o_pre.mag      = i_raw;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: src/p2f_pack.sv
// ----------------------------------------------------------------------------
// p2f_pack: normalize, round and pack
// Leading-one detect, round to nearest-even to 24 bits, float clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module p2f_pack (
    input  wire p2f_pkg::t_p2f_pre i_pre,
    output logic [31:0]         o_bits
);
    logic [4:0]  msb;
    logic [31:0] norm;
    logic [24:0] mant_r;
    logic        rnd;
    logic [7:0]  expo;
    logic [30:0] fmag;

    always_comb begin
        msb = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (i_pre.mag[k]) msb = 5'(k);
        end
    end

    // msb lands at bit 31; low 8 bits are round/sticky
    assign norm   = i_pre.mag << (5'd31 - msb);
    assign rnd    = norm[7] & ((|norm[6:0]) | norm[8]);
    assign mant_r = {1'b0, norm[31:8]} + {24'd0, rnd};
    assign expo   = i_pre.exp_bias + {3'd0, msb} + {7'd0, mant_r[24]};
    assign fmag   = i_pre.mag[30:0];

    always_comb begin
        if (i_pre.is_float) begin
            if ({1'b0, fmag} > p2f_pkg::F32_INF)          o_bits = p2f_pkg::F32_POS_ONE;
            else if ({1'b0, fmag} > p2f_pkg::F32_POS_ONE)
                o_bits = i_pre.mag[31] ? p2f_pkg::F32_NEG_ONE : p2f_pkg::F32_POS_ONE;
            else                                           o_bits = i_pre.mag;
        end else if (i_pre.mag == 32'd0) begin
            o_bits = 32'd0;
        end else begin
            // on carry-out the mantissa field is zero either way
            o_bits = {i_pre.neg, expo, mant_r[22:0]};
        end
    end
endmodule
`default_nettype wire

FILE: src/pcm_to_float32_converter_core.sv
// ----------------------------------------------------------------------------
// pcm_to_float32_converter_core: PCM sample to float32 converter
// Input register, one pass of decode/normalize/round, result register.
// ----------------------------------------------------------------------------
// channel   dir  tdata                 tuser
// s_axis    in   raw_sample[31:0]      last via tlast
// m_axis    out  float_bits[31:0]      last via tlast
// cfg       in   sample_format[1:0]    -
//
// A beat passes the input register, then the result register; one beat per cycle while m_axis does not stall.
// Input register and result register each advance when the next stage can take.
// Reset clears the valid flags and sets sample_format to signed 16-bit.
// Stall on m_axis holds both stages; s_axis_tready falls only when both full.
`default_nettype none
module pcm_to_float32_converter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata,     // sample_format
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,    // [31:0] raw_sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,    // [31:0] float_bits
    output logic             m_axis_tlast
);
    logic [1:0]  r_fmt;
    logic        r_in_vld, r_out_vld;
    logic [31:0] r_raw, r_out;
    logic        r_in_last, r_out_last;
    logic        adv_out, adv_in;
    logic [31:0] bits;
    p2f_pkg::t_p2f_pre pre;

    assign adv_out       = r_in_vld & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_in_vld | adv_out;
    assign adv_in        = s_axis_tvalid & s_axis_tready;

    p2f_front u_front (.i_fmt(r_fmt), .i_raw(r_raw), .i_last(r_in_last), .o_pre(pre));
    p2f_pack  u_pack  (.i_pre(pre), .o_bits(bits));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= p2f_pkg::FMT_S16;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_wdata;
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (~r_out_vld | m_axis_tready) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_raw     <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (adv_out) begin
            r_out      <= bits;
            r_out_last <= pre.last;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_vld && r_out_vld && !m_axis_tready)
        else $error("input stalled without back-pressure");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv_out |=> m_axis_tvalid && m_axis_tlast == $past(r_in_last))
        else $error("result not registered");
endmodule
`default_nettype wire
